FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication form of the above, for readability at the point of use.
`define ASSERT_IMPL(label, ante, cons, msg) \
  `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

FILE: rtl/core/bbc_pkg.sv
// ---------------------------------------------------------------------------
// bbc_pkg
// Types, codes and character helpers for the bracket balance checker.
// ---------------------------------------------------------------------------
package bbc_pkg;

  // Request payloads.
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_expression;
  } bbc_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] nesting_depth;
    logic       verdict_final;
  } bbc_out_t;

  // Status codes.
  localparam logic [2:0] ST_PENDING  = 3'd0;
  localparam logic [2:0] ST_VALID    = 3'd1;
  localparam logic [2:0] ST_EXTRA    = 3'd2;
  localparam logic [2:0] ST_MISMATCH = 3'd3;
  localparam logic [2:0] ST_UNCLOSED = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  // Bracket kinds as held on the stack.
  localparam logic [1:0] KIND_PAREN  = 2'd0;
  localparam logic [1:0] KIND_SQUARE = 2'd1;
  localparam logic [1:0] KIND_CURLY  = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LSQUARE = 8'h5B;
  localparam logic [7:0] CH_RSQUARE = 8'h5D;
  localparam logic [7:0] CH_LCURLY  = 8'h7B;
  localparam logic [7:0] CH_RCURLY  = 8'h7D;

  // Stack operation issued by the control logic for one accepted request.
  typedef struct packed {
    logic       push;
    logic       pop;
    logic       clear;
    logic [1:0] kind;
  } bbc_stk_op_t;

  function automatic logic [1:0] open_kind(input logic [7:0] c);
    logic [1:0] k;
    unique case (c)
      CH_LPAREN:  k = KIND_PAREN;
      CH_LSQUARE: k = KIND_SQUARE;
      CH_LCURLY:  k = KIND_CURLY;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [1:0] close_kind(input logic [7:0] c);
    logic [1:0] k;
    unique case (c)
      CH_RPAREN:  k = KIND_PAREN;
      CH_RSQUARE: k = KIND_SQUARE;
      CH_RCURLY:  k = KIND_CURLY;
      default:    k = KIND_NONE;
    endcase
    return k;
  endfunction

endpackage

FILE: rtl/core/bbc_ram.sv
// ---------------------------------------------------------------------------
// bbc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bbc_stack.sv
// ---------------------------------------------------------------------------
// bbc_stack
// Bracket stack: top entry in a register, the rest in a RAM, with the entry
// below the top prefetched every cycle so that a pop need not wait for the RAM.
// ---------------------------------------------------------------------------
module bbc_stack import bbc_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  bbc_stk_op_t                        op,
  output logic [1:0]                         top_kind,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    top_r, top_nxt;
  logic          fwd_r, fwd_nxt;
  logic [1:0]    fwd_data_r;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [CW-1:0] waddr_full, raddr_full;
  logic [1:0]    rd_data, below;

  // The entry below the top: from the RAM, or from last cycle's write when
  // that write went to the address being read.
  assign below = fwd_r ? fwd_data_r : rd_data;

  always_comb begin
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    we         = 1'b0;
    waddr_full = cnt_r - CW'(1);
    priority if (op.clear) begin
      cnt_nxt = '0;
    end else if (op.push) begin
      // The old top moves down into the RAM.
      we      = (cnt_r != '0);
      top_nxt = op.kind;
      cnt_nxt = cnt_r + CW'(1);
    end else if (op.pop) begin
      top_nxt = below;
      cnt_nxt = cnt_r - CW'(1);
    end
    raddr_full = cnt_nxt - CW'(2);
    waddr      = waddr_full[AW-1:0];
    raddr      = raddr_full[AW-1:0];
    fwd_nxt    = we && (waddr == raddr);
  end

  bbc_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top_r),
    .raddr (raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fwd_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      fwd_r <= fwd_nxt;
    end
    top_r      <= top_nxt;
    fwd_data_r <= top_r;
  end

  assign top_kind = top_r;
  assign count    = cnt_r;

endmodule

FILE: rtl/core/bracket_balance_checker.sv
// ---------------------------------------------------------------------------
// bracket_balance_checker
// Streaming check that the brackets of an expression are balanced.
// ---------------------------------------------------------------------------
// Usage: each input request carries one character of an expression and a
// flag on its last character. Every request yields exactly one result
// request, with a status, the nesting depth after the character and a flag
// that marks the final verdict of the expression.
// The result is registered: a request accepted at a clock edge shows its
// result on out_valid from that edge. One request is taken per cycle while
// the receiver does not stall; stack push or pop and the compare with the
// top kind are done in the cycle of acceptance, with the top kept in a
// register and the entry below prefetched from the stack RAM (one read port).
// Reset (rst_n low, synchronous) empties the stack, clears the sticky error
// and drops out_valid. The stack RAM itself is not cleared; an entry is
// only read after it has been written.
// When the receiver stalls, the result is held in the output register and
// in_stall rises in the same cycle, so no further request is taken until
// the held result has gone.
// ---------------------------------------------------------------------------
module bracket_balance_checker import bbc_pkg::*; #(
  parameter int STACK_DEPTH = 128
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bbc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bbc_out_t out_data
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic          accept;
  logic [1:0]    ok, ck;
  logic [2:0]    err_r, err_nxt;
  logic          push, pop;
  logic [CW-1:0] cnt, depth;
  logic [1:0]    top_kind;
  logic [CW+7:0] depth_wide;
  bbc_stk_op_t   op;
  logic          out_valid_r, out_valid_nxt;
  bbc_out_t      out_data_r, out_data_nxt;

  // The output register is the only buffer: a new request may enter
  // whenever the register is empty or its content leaves this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign ok = open_kind(in_data.char_code);
  assign ck = close_kind(in_data.char_code);

  // Decide the stack operation and the new sticky error. Once an error has
  // been seen the rest of the expression leaves the stack alone.
  always_comb begin
    err_nxt = err_r;
    push    = 1'b0;
    pop     = 1'b0;
    depth   = cnt;
    if (err_r == ST_PENDING) begin
      if (ok != KIND_NONE) begin
        if (cnt >= CW'(STACK_DEPTH)) begin
          err_nxt = ST_OVERFLOW;
        end else begin
          push  = 1'b1;
          depth = cnt + CW'(1);
        end
      end else if (ck != KIND_NONE) begin
        if (cnt == '0) begin
          err_nxt = ST_EXTRA;
        end else begin
          // A mismatched closer still pops the top entry.
          pop   = 1'b1;
          depth = cnt - CW'(1);
          if (top_kind != ck) begin
            err_nxt = ST_MISMATCH;
          end
        end
      end
    end
  end

  always_comb begin
    op.push  = accept && push;
    op.pop   = accept && pop;
    op.clear = accept && in_data.end_of_expression;
    op.kind  = ok;
  end

  bbc_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .top_kind (top_kind),
    .count    (cnt)
  );

  // The depth is reported modulo 256, as the field is eight bits wide.
  assign depth_wide = {8'd0, depth};

  always_comb begin
    out_data_nxt.nesting_depth = depth_wide[7:0];
    out_data_nxt.verdict_final = in_data.end_of_expression;
    if (in_data.end_of_expression) begin
      if (err_nxt != ST_PENDING) begin
        out_data_nxt.status = err_nxt;
      end else if (depth != '0) begin
        out_data_nxt.status = ST_UNCLOSED;
      end else begin
        out_data_nxt.status = ST_VALID;
      end
    end else begin
      out_data_nxt.status = err_nxt;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      err_r       <= ST_PENDING;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        // The end of an expression starts the next one free of error.
        err_r <= in_data.end_of_expression ? ST_PENDING : err_nxt;
      end
    end
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/bbc_checker.sv
// ---------------------------------------------------------------------------
// bbc_checker
// Port-level assertions for the bracket balance checker, bound to its top.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bbc_checker import bbc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_stall,
  input bbc_out_t out_data
);

  // A stalled result stays offered.
  `ASSERT_IMPL(a_out_hold, out_valid && out_stall, ##1 out_valid, "result dropped under stall")

  // A stalled result does not change.
  `ASSERT_IMPL(a_out_stable, out_valid && out_stall, ##1 $stable(out_data), "stalled result changed")

  // Valid and unclosed are only given as final verdicts.
  `ASSERT_IMPL(a_final_only, out_valid && !out_data.verdict_final, out_data.status != ST_VALID && out_data.status != ST_UNCLOSED, "verdict status on a pending result")

  // A balanced expression ends with nothing open.
  `ASSERT_IMPL(a_valid_empty, out_valid && out_data.status == ST_VALID, out_data.nesting_depth == 8'd0, "valid verdict with open brackets")

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);

FILE: tb/tb_bracket_balance_checker.sv
// ---------------------------------------------------------------------------
// tb_bracket_balance_checker
// Self-checking testbench for the streaming bracket balance checker.
// ---------------------------------------------------------------------------
// Expressions are sent one character per request. A predictor written here
// mirrors the checker: a bracket stack, its depth and the sticky first error
// of the current expression. Every accepted request queues the result that
// the checker should return. Each returned result is compared field by
// field with the oldest queued one. Both sides of the handshake idle at
// random, except for one calm stretch of the random test.
// ---------------------------------------------------------------------------
module tb_bracket_balance_checker;
  timeunit 1ns;
  timeprecision 1ps;

  import bbc_pkg::*;

  localparam int STACK_DEPTH = 128;

  // Bracket class of one character, as the predictor sees it.
  typedef struct packed {
    logic       opening;
    logic       closing;
    logic [1:0] kind;
  } bracket_t;

  // Expression styles of the random test.
  typedef enum int {
    STYLE_BALANCED,
    STYLE_DEEP,
    STYLE_BROKEN,
    STYLE_NOISE
  } expr_style_e;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bbc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bbc_out_t out_data;

  // While calm is high neither side idles.
  logic calm = 1'b0;

  // Predictor state: the stack of open bracket kinds, its depth and the
  // first error seen in the current expression (ST_PENDING when none).
  logic [1:0]  held_kinds [STACK_DEPTH];
  int unsigned held_depth = 0;
  logic [2:0]  sticky_error = ST_PENDING;

  // Results still to come back from the checker, oldest first.
  bbc_out_t awaited_results [$];
  int unsigned failures = 0;

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 4 ns clock period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bracket_t classify(input logic [7:0] c);
    bracket_t b;
    b = '{1'b0, 1'b0, KIND_NONE};
    case (c)
      CH_LPAREN:  b = '{1'b1, 1'b0, KIND_PAREN};
      CH_LSQUARE: b = '{1'b1, 1'b0, KIND_SQUARE};
      CH_LCURLY:  b = '{1'b1, 1'b0, KIND_CURLY};
      CH_RPAREN:  b = '{1'b0, 1'b1, KIND_PAREN};
      CH_RSQUARE: b = '{1'b0, 1'b1, KIND_SQUARE};
      CH_RCURLY:  b = '{1'b0, 1'b1, KIND_CURLY};
      default:    b = '{1'b0, 1'b0, KIND_NONE};
    endcase
    return b;
  endfunction

  function automatic logic [7:0] opening_char(input logic [1:0] kind);
    case (kind)
      KIND_PAREN:  return CH_LPAREN;
      KIND_SQUARE: return CH_LSQUARE;
      default:     return CH_LCURLY;
    endcase
  endfunction

  function automatic logic [7:0] closing_char(input logic [1:0] kind);
    case (kind)
      KIND_PAREN:  return CH_RPAREN;
      KIND_SQUARE: return CH_RSQUARE;
      default:     return CH_RCURLY;
    endcase
  endfunction

  // Works out the result of one character and advances the predictor.
  function automatic bbc_out_t judge_char(input bbc_in_t req);
    bbc_out_t res;
    bracket_t b;
    b = classify(req.char_code);
    // Once an error is held, the rest of the expression leaves the stack
    // untouched.
    if (sticky_error == ST_PENDING) begin
      if (b.opening) begin
        if (held_depth >= STACK_DEPTH) begin
          sticky_error = ST_OVERFLOW;
        end else begin
          held_kinds[held_depth] = b.kind;
          held_depth++;
        end
      end else if (b.closing) begin
        if (held_depth == 0) begin
          sticky_error = ST_EXTRA;
        end else begin
          // The top is popped even when its kind does not match.
          held_depth--;
          if (held_kinds[held_depth] != b.kind) sticky_error = ST_MISMATCH;
        end
      end
    end
    res.nesting_depth = 8'(held_depth);
    res.verdict_final = req.end_of_expression;
    if (!req.end_of_expression || sticky_error != ST_PENDING) begin
      res.status = sticky_error;
    end else if (held_depth != 0) begin
      res.status = ST_UNCLOSED;
    end else begin
      res.status = ST_VALID;
    end
    // The verdict shows the depth before the expression is cleared.
    if (req.end_of_expression) begin
      held_depth = 0;
      sticky_error = ST_PENDING;
    end
    return res;
  endfunction

  // Presents one character, waits for it to be taken and queues its result.
  // Valid stays high after acceptance, so back-to-back requests never lower
  // and raise it within one time step.
  task automatic send_char(input logic [7:0] c, input logic last);
    bbc_in_t req;
    req.char_code = c;
    req.end_of_expression = last;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    awaited_results.push_back(judge_char(req));
  endtask

  task automatic send_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      send_char(text[i], i == text.len() - 1);
    end
  endtask

  task automatic report_mismatch(input string what, input bbc_out_t want,
                                 input bbc_out_t got);
    failures++;
    if (failures <= 10) begin
      $display("[%0t] %s: expected %0d/%0d/%0b, got %0d/%0d/%0b",
               $realtime, what, want.status, want.nesting_depth, want.verdict_final,
               got.status, got.nesting_depth, got.verdict_final);
    end
  endtask

  // The receiver stalls in about 30 percent of cycles, never while calm.
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 30);
  end

  // Every result taken from the checker is compared with the oldest one
  // still awaited.
  always @(posedge clk) begin : result_check
    bbc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited", '0, out_data);
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status ||
            out_data.nesting_depth !== want.nesting_depth ||
            out_data.verdict_final !== want.verdict_final) begin
          report_mismatch("result mismatch", want, out_data);
        end
      end
    end
  end

  // Well-formed expressions, every bracket kind and the extreme byte values.
  task automatic test_plain_expressions();
    send_text("([{}])");
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
  endtask

  // Each error, and characters that follow an error being ignored.
  task automatic test_error_cases();
    send_text(")");         // closing bracket on an empty stack
    send_text("(]");        // wrong kind, detected on the last character
    send_text("{");         // left open at the end
    send_text("](x");       // extra close, then later characters ignored
    send_text("[)}");       // mismatch held while a further close arrives
  endtask

  // Stack filled to the brim, left full at the end, and pushed past full.
  task automatic test_stack_limits();
    logic [1:0] kinds [$];
    logic [1:0] kind;
    logic [7:0] c;
    // Exactly full, then unwound in order: a valid verdict.
    for (int k = 0; k < STACK_DEPTH; k++) begin
      kind = 2'($urandom_range(2));
      kinds.push_back(kind);
      send_char(opening_char(kind), 1'b0);
    end
    while (kinds.size() > 0) begin
      kind = kinds.pop_back();
      send_char(closing_char(kind), kinds.size() == 0);
    end
    // Full when the expression ends: unclosed at the deepest depth.
    for (int k = 0; k < STACK_DEPTH; k++) begin
      send_char(opening_char(2'($urandom_range(2))), k == STACK_DEPTH - 1);
    end
    // One opening bracket too many, followed by characters to be ignored.
    for (int k = 0; k <= STACK_DEPTH; k++) begin
      kind = 2'($urandom_range(2));
      send_char(opening_char(kind), 1'b0);
    end
    send_char(closing_char(kind), 1'b0);
    c = "x";
    send_char(c, 1'b1);
  endtask

  // Random expressions: mostly balanced ones with random content, some deep
  // ones, some with stray or missing brackets, and some pure noise.
  task automatic test_random_expressions(input int unsigned budget);
    logic [1:0]  opens [$];
    logic [7:0]  text [$];
    logic [7:0]  c;
    bracket_t    b;
    expr_style_e style;
    int unsigned sent;
    int unsigned span;
    int unsigned pick;
    int unsigned open_share;
    sent = 0;
    while (sent < budget) begin
      // One long stretch runs with neither side idling.
      calm <= (sent >= 500 && sent < 800);
      pick = $urandom_range(99);
      if (pick < 55) begin
        style = STYLE_BALANCED;
      end else if (pick < 62) begin
        style = STYLE_DEEP;
      end else if (pick < 82) begin
        style = STYLE_BROKEN;
      end else begin
        style = STYLE_NOISE;
      end
      span = (style == STYLE_DEEP) ? $urandom_range(260, 100) : $urandom_range(24, 1);
      open_share = (style == STYLE_DEEP) ? 55 : 35;
      opens.delete();
      text.delete();
      for (int k = 0; k < span; k++) begin
        pick = $urandom_range(99);
        if (style == STYLE_NOISE) begin
          c = 8'($urandom_range(255));
        end else if (pick < open_share && opens.size() < STACK_DEPTH) begin
          opens.push_back(2'($urandom_range(2)));
          c = opening_char(opens[$]);
        end else if (pick < open_share + 30 && opens.size() > 0) begin
          c = closing_char(opens.pop_back());
        end else begin
          do begin
            c = 8'($urandom_range(255));
            b = classify(c);
          end while (b.opening || b.closing);
        end
        // Broken expressions get the odd stray closing bracket.
        if (style == STYLE_BROKEN && $urandom_range(9) == 0) begin
          c = closing_char(2'($urandom_range(2)));
        end
        text.push_back(c);
      end
      // Balanced and deep expressions are closed off; broken ones only
      // sometimes, so that some are left open at the end.
      if (style != STYLE_NOISE && (style != STYLE_BROKEN || $urandom_range(1) == 1)) begin
        while (opens.size() > 0) text.push_back(closing_char(opens.pop_back()));
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1);
      sent += text.size();
    end
    calm <= 1'b0;
  endtask

  initial begin : main_sequence
    int unsigned drain_cycles;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_expressions();
    test_error_cases();
    test_stack_limits();
    test_random_expressions(1120);
    in_valid <= 1'b0;

    // Let the last results come back before the verdict is printed.
    drain_cycles = 0;
    while (awaited_results.size() != 0 && drain_cycles < 2000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);

    if (failures == 0 && awaited_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run needs.
  initial begin : watchdog
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/bbc_pkg.sv
rtl/core/bbc_ram.sv
rtl/core/bbc_stack.sv
rtl/core/bracket_balance_checker.sv
rtl/core/bbc_checker.sv
tb/tb_bracket_balance_checker.sv
